/* rtl/leb128_value_decoder_unit_defines.svh */
// Assertion macros used by the checker of the value decoder.
// Each macro samples on i_clk and is switched off while i_rst_n is low.
`ifndef LEB128_VALUE_DECODER_UNIT_DEFINES_SVH
`define LEB128_VALUE_DECODER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LVD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("value decoder check failed");

// Consequent must hold in the cycle after the antecedent.
`define LVD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("value decoder check failed");

`endif

/* rtl/leb_vd_pkg.sv */
`default_nettype none

package leb_vd_pkg;

    // Read modes carried with every byte.
    typedef enum logic [3:0] {
        MODE_U8     = 4'd0,
        MODE_U32BE  = 4'd1,
        MODE_U64BE  = 4'd2,
        MODE_BOOL   = 4'd3,
        MODE_U7     = 4'd4,
        MODE_S32LEB = 4'd5,
        MODE_U32LEB = 4'd6,
        MODE_S64LEB = 4'd7,
        MODE_U64LEB = 4'd8,
        MODE_FIX32  = 4'd9,
        MODE_FIX64  = 4'd10
    } t_mode;

    // Error codes reported with each value.
    typedef enum logic [1:0] {
        ERR_OK   = 2'd0,
        ERR_BOOL = 2'd1,
        ERR_BYTE = 2'd2,
        ERR_LONG = 2'd3
    } t_err;

    localparam int VALUE_W     = 64;
    localparam int SHIFT_W     = 7;
    localparam int COUNT_W     = 4;
    localparam int SHIFT_STEP  = 7;
    localparam int SHIFT_SAT   = 127;
    localparam int LEB32_BYTES = 5;
    localparam int LEB64_BYTES = 10;
    localparam int MAX_BYTES   = 10;

endpackage

`default_nettype wire

/* rtl/leb128_value_decoder_unit.sv */
// Byte-serial value decoder.
// Input channel: i_valid / o_stall carry one stream byte (i_data_byte) with the
// read mode (i_mode) and, for the fixed modes, a bit count (i_num_bits). A
// transfer happens at a rising edge where i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall carry one finished value (o_value) with
// its error code and the number of bytes that formed it. A transfer happens
// where o_valid is high and i_stall is low. Bytes that do not finish a value,
// and bytes under an unused mode, produce no output transfer.
// A byte passes through the input register and then the result register; it
// leaves the input register once the result register is free or being emptied,
// and a byte that completes a value shows its result from the result register.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// single accumulate step between the input register and the result register.
// When the receiver stalls with a result waiting, the input register holds
// one further byte and then o_stall rises until the result is taken.
// Reset (synchronous, i_rst_n low) empties both registers and clears the
// accumulator, shift position and byte count, so decoding restarts idle.
`default_nettype none

module leb128_value_decoder_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output      logic                 o_stall,
    input  wire logic [3:0]           i_mode,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic [6:0]           i_num_bits,
    output      logic                 o_valid,
    input  wire logic                 i_stall,
    output      logic [63:0]          o_value,
    output      leb_vd_pkg::t_err     o_error_code,
    output      logic [3:0]           o_bytes_used
);
    import leb_vd_pkg::*;

    // Input register.
    logic                 r_in_valid;
    logic [3:0]           r_mode;
    logic [7:0]           r_byte;
    logic [6:0]           r_num_bits;

    // Decoder state.
    logic [VALUE_W-1:0]   r_acc;
    logic [SHIFT_W-1:0]   r_shift;
    logic [COUNT_W-1:0]   r_count;
    logic [VALUE_W-1:0]   n_acc;
    logic [SHIFT_W-1:0]   n_shift;
    logic [COUNT_W-1:0]   n_count;

    // Result register.
    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_value;
    t_err                 r_error;
    logic [COUNT_W-1:0]   r_used;
    logic                 n_done;
    logic [VALUE_W-1:0]   n_value;
    t_err                 n_error;

    logic                 advance;
    logic                 in_accept;

    // Combinational working signals.
    logic                 byte_mode;
    logic                 leb_mode;
    logic                 is32;
    logic                 sgn;
    logic [3:0]           len;
    logic [3:0]           fix_len;
    logic [3:0]           max_bytes;
    logic [COUNT_W-1:0]   count_inc;
    logic [SHIFT_W:0]     shift_sum;
    logic [SHIFT_W-1:0]   shift_upd;
    logic [VALUE_W-1:0]   byte_acc;
    logic [VALUE_W-1:0]   leb_acc;
    logic [31:0]          val32;
    logic                 more;

    // The byte in the input register moves on whenever the result register
    // is free or is being emptied in this cycle.
    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    always_comb begin
        byte_mode = 1'b0;
        leb_mode  = 1'b0;
        is32      = 1'b0;
        sgn       = 1'b0;
        len       = 4'd1;
        n_acc     = r_acc;
        n_shift   = r_shift;
        n_count   = r_count;
        n_done    = 1'b0;
        n_value   = r_acc;
        n_error   = ERR_OK;
        val32     = 32'd0;

        count_inc = r_count + COUNT_W'(1);
        shift_sum = {1'b0, r_shift} + (SHIFT_W+1)'(SHIFT_STEP);
        shift_upd = (shift_sum > (SHIFT_W+1)'(SHIFT_SAT)) ? SHIFT_W'(SHIFT_SAT)
                                                          : shift_sum[SHIFT_W-1:0];
        more      = r_byte[7];

        // Fixed reads: up to 8 bits is one byte, up to 32 is four, else eight.
        if (r_num_bits <= 7'd8) begin
            fix_len = 4'd1;
        end else if (r_num_bits <= 7'd32) begin
            fix_len = 4'd4;
        end else begin
            fix_len = 4'd8;
        end

        byte_acc = {r_acc[VALUE_W-9:0], r_byte};
        // LEB payload bits at or beyond bit 64 are dropped.
        leb_acc  = (r_shift < 7'd64)
                 ? (r_acc | ({57'd0, r_byte[6:0]} << r_shift[5:0]))
                 : r_acc;

        unique case (r_mode) inside
            MODE_U8, MODE_BOOL, MODE_U7: begin
                byte_mode = 1'b1;
                len       = 4'd1;
            end
            MODE_U32BE: begin
                byte_mode = 1'b1;
                len       = 4'd4;
            end
            MODE_U64BE: begin
                byte_mode = 1'b1;
                len       = 4'd8;
            end
            MODE_FIX32: begin
                byte_mode = 1'b1;
                len       = (fix_len > 4'd4) ? 4'd4 : fix_len;
            end
            MODE_FIX64: begin
                byte_mode = 1'b1;
                len       = fix_len;
            end
            MODE_S32LEB: begin
                leb_mode = 1'b1;
                is32     = 1'b1;
                sgn      = 1'b1;
            end
            MODE_U32LEB: begin
                leb_mode = 1'b1;
                is32     = 1'b1;
            end
            MODE_S64LEB: begin
                leb_mode = 1'b1;
                sgn      = 1'b1;
            end
            MODE_U64LEB: begin
                leb_mode = 1'b1;
            end
            default: begin
                // Unused modes leave the state untouched.
            end
        endcase

        max_bytes = is32 ? 4'(LEB32_BYTES) : 4'(LEB64_BYTES);

        if (byte_mode) begin
            n_acc   = byte_acc;
            n_count = count_inc;
            n_done  = (count_inc >= len);
            if (len >= 4'd8) begin
                n_value = byte_acc;
            end else if (len == 4'd4) begin
                n_value = {32'd0, byte_acc[31:0]};
            end else begin
                n_value = {56'd0, byte_acc[7:0]};
            end
            if ((r_mode == MODE_BOOL) && (r_byte > 8'd1)) begin
                n_error = ERR_BOOL;
            end else if ((r_mode == MODE_U7) && r_byte[7]) begin
                n_error = ERR_BYTE;
            end
        end else if (leb_mode) begin
            n_acc   = leb_acc;
            n_shift = shift_upd;
            n_count = count_inc;
            n_done  = !more || (count_inc >= max_bytes);
            n_value = leb_acc;
            if (more) begin
                // Overlong varint: the bits so far, with no sign fill.
                n_error = ERR_LONG;
                if (is32) begin
                    n_value = {32'd0, leb_acc[31:0]};
                end
            end else if (is32) begin
                val32 = leb_acc[31:0];
                if (sgn && (shift_upd < 7'd32) && r_byte[6]) begin
                    val32 = val32 | (32'hFFFF_FFFF << shift_upd[4:0]);
                end
                n_value = sgn ? {{32{val32[31]}}, val32} : {32'd0, val32};
            end else if (sgn && (shift_upd < 7'd64) && r_byte[6]) begin
                n_value = leb_acc | ({VALUE_W{1'b1}} << shift_upd[5:0]);
            end
        end

        // A finished value returns the decoder to idle.
        if (n_done) begin
            n_acc   = '0;
            n_shift = '0;
            n_count = '0;
        end
    end

    // Control and decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_shift     <= '0;
            r_count     <= '0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
            if (advance) begin
                r_acc   <= n_acc;
                r_shift <= n_shift;
                r_count <= n_count;
            end
            if (advance && n_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode     <= i_mode;
            r_byte     <= i_data_byte;
            r_num_bits <= i_num_bits;
        end
        if (advance && n_done) begin
            r_value <= n_value;
            r_error <= n_error;
            r_used  <= count_inc;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_value      = r_value;
    assign o_error_code = r_error;
    assign o_bytes_used = r_used;

endmodule

`default_nettype wire

/* rtl/leb_vd_checker.sv */
`default_nettype none

`include "leb128_value_decoder_unit_defines.svh"

module leb_vd_checker (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic                 o_stall,
    input  wire logic [3:0]           i_mode,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic [6:0]           i_num_bits,
    input  wire logic                 o_valid,
    input  wire logic                 i_stall,
    input  wire logic [63:0]          o_value,
    input  wire leb_vd_pkg::t_err     o_error_code,
    input  wire logic [3:0]           o_bytes_used
);
    import leb_vd_pkg::*;

    logic used_ok;
    logic bool_err_out;
    logic bool_byte_ok;
    logic byte_err_out;
    logic wide_byte_ok;

    assign used_ok      = (o_bytes_used != 4'd0) && (o_bytes_used <= 4'(MAX_BYTES));
    assign bool_err_out = o_valid && (o_error_code == ERR_BOOL);
    assign bool_byte_ok = (o_value[63:8] == 56'd0) && (o_value[7:1] != 7'd0);
    assign byte_err_out = o_valid && (o_error_code == ERR_BYTE);
    assign wide_byte_ok = (o_value[63:8] == 56'd0) && o_value[7];

    // A stalled result stays offered and unchanged.
    `LVD_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_value))

    // Every value is formed from one to ten bytes.
    `LVD_ASSERT_SAME(a_used_range, o_valid, used_ok)

    // A boolean error carries the offending byte, which is above one.
    `LVD_ASSERT_SAME(a_bool_err, bool_err_out, bool_byte_ok)

    // A 7-bit error carries a byte with its top bit set.
    `LVD_ASSERT_SAME(a_byte_err, byte_err_out, wide_byte_ok)

endmodule

bind leb128_value_decoder_unit leb_vd_checker u_leb_vd_checker (.*);

`default_nettype wire

/* bench/tb_leb128_value_decoder_unit.sv */
`timescale 1ns / 1ps

module tb_leb128_value_decoder_unit;

    import leb_vd_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_BYTES   = 360;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 10;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_style;

    typedef struct packed {
        logic [63:0] value;
        t_err        err;
        logic [3:0]  used;
    } t_value_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [3:0]  i_mode      = 4'd0;
    logic [7:0]  i_data_byte = 8'd0;
    logic [6:0]  i_num_bits  = 7'd0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [63:0] o_value;
    t_err        o_error_code;
    logic [3:0]  o_bytes_used;

    // Decoder state as predicted from the accepted byte stream.
    logic [63:0] acc_q   = '0;
    int unsigned shift_q = 0;
    logic [3:0]  count_q = '0;

    t_value_result expected_values[$];

    int           fail_count     = 0;
    int           bytes_sent     = 0;
    int           values_checked = 0;
    int           err_seen[4]    = '{0, 0, 0, 0};
    int           burst_left     = 0;
    bit           gaps_on        = 1'b0;
    t_stall_style stall_style    = STALL_NONE;
    bit           hold_req       = 1'b0;
    bit           hold_ack       = 1'b0;
    int           hold_left      = 0;
    int           stall_phase    = 0;
    int           idle_count     = 0;

    leb128_value_decoder_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_data_byte  (i_data_byte),
        .i_num_bits   (i_num_bits),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_value      (o_value),
        .o_error_code (o_error_code),
        .o_bytes_used (o_bytes_used)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Bytes taken by a fixed read of the given bit count, limited by the word size.
    function automatic int unsigned fixed_bytes(input logic [6:0] nb, input int unsigned cap);
        int unsigned n;
        n = (nb <= 8) ? 1 : ((nb <= 32) ? 4 : 8);
        return (n > cap) ? cap : n;
    endfunction

    // Advances the predicted state by one byte; returns 1 when a value completes.
    function automatic bit decode_stream_byte(input logic [3:0] m, input logic [7:0] b,
                                              input logic [6:0] nb, output t_value_result res);
        int unsigned len;
        int unsigned maxb;
        bit          is32;
        bit          sgn;
        bit          more;
        logic [63:0] data;
        logic [63:0] val;
        t_err        err;
        res = '0;
        err = ERR_OK;
        if (m > MODE_FIX64)
            return 1'b0;
        if (m <= MODE_U7 || m >= MODE_FIX32) begin
            case (m)
                MODE_U32BE: len = 4;
                MODE_U64BE: len = 8;
                MODE_FIX32: len = fixed_bytes(nb, 4);
                MODE_FIX64: len = fixed_bytes(nb, 8);
                default:    len = 1;
            endcase
            acc_q   = {acc_q[55:0], b};
            count_q = count_q + 4'd1;
            if (count_q < len)
                return 1'b0;
            val = (len >= 8) ? acc_q : (acc_q & ((64'd1 << (len * 8)) - 64'd1));
            if (m == MODE_BOOL && b > 8'd1)
                err = ERR_BOOL;
            else if (m == MODE_U7 && b > 8'd127)
                err = ERR_BYTE;
        end else begin
            is32 = (m == MODE_S32LEB || m == MODE_U32LEB);
            sgn  = (m == MODE_S32LEB || m == MODE_S64LEB);
            maxb = is32 ? LEB32_BYTES : LEB64_BYTES;
            data = {57'd0, b[6:0]};
            more = b[7];
            if (shift_q < 64)
                acc_q |= data << shift_q;
            shift_q = (shift_q + SHIFT_STEP > SHIFT_SAT) ? SHIFT_SAT : shift_q + SHIFT_STEP;
            count_q = count_q + 4'd1;
            if (more && count_q < maxb)
                return 1'b0;
            val = acc_q;
            if (more) begin
                // Overlong: whatever has been gathered, with no sign fill.
                err = ERR_LONG;
                if (is32)
                    val[63:32] = '0;
            end else if (is32) begin
                val[63:32] = '0;
                if (sgn) begin
                    if (shift_q < 32 && data[6])
                        val[31:0] = val[31:0] | (32'hFFFF_FFFF << shift_q);
                    if (val[31])
                        val[63:32] = '1;
                end
            end else if (sgn && shift_q < 64 && data[6]) begin
                val |= {64{1'b1}} << shift_q;
            end
        end
        res.value = val;
        res.err   = err;
        res.used  = count_q;
        acc_q     = '0;
        shift_q   = 0;
        count_q   = '0;
        return 1'b1;
    endfunction

    // Prediction first, then the check, so the order within an edge is fixed.
    always @(posedge i_clk) begin
        t_value_result res;
        t_value_result exp_res;
        if (i_rst_n && i_valid && !o_stall) begin
            if (decode_stream_byte(i_mode, i_data_byte, i_num_bits, res))
                expected_values.push_back(res);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_values.size() == 0) begin
                $display("%0t: unexpected result, actual value %h error %0d bytes %0d",
                         $time, o_value, o_error_code, o_bytes_used);
                fail_count++;
            end else begin
                exp_res = expected_values.pop_front();
                values_checked++;
                err_seen[exp_res.err]++;
                if (o_value !== exp_res.value) begin
                    $display("%0t: value mismatch, expected %h actual %h",
                             $time, exp_res.value, o_value);
                    fail_count++;
                end
                if (o_error_code !== exp_res.err) begin
                    $display("%0t: error code mismatch, expected %0d actual %0d",
                             $time, exp_res.err, o_error_code);
                    fail_count++;
                end
                if (o_bytes_used !== exp_res.used) begin
                    $display("%0t: byte count mismatch, expected %0d actual %0d",
                             $time, exp_res.used, o_bytes_used);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: a chosen stall pattern, overridden by a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall     <= 1'b0;
            hold_left   <= 0;
            hold_ack    <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (hold_left != 0) begin
                i_stall   <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (hold_req != hold_ack) begin
                hold_ack  <= hold_req;
                hold_left <= HOLD_CYCLES - 1;
                i_stall   <= 1'b1;
            end else begin
                case (stall_style)
                    STALL_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    i_stall <= ($urandom_range(0, 9) < 7);
                    STALL_PERIODIC: i_stall <= ((stall_phase % 11) < 4);
                    default:        i_stall <= 1'b0;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_count <= 0;
        end else if (idle_count >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d values still awaited",
                     $time, idle_count, expected_values.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    function automatic logic [7:0] biased_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offers one byte until it is taken, then maybe pauses between bursts.
    task automatic send_byte(input logic [3:0] m, input logic [7:0] b, input logic [6:0] nb);
        int gap;
        i_valid     <= 1'b1;
        i_mode      <= m;
        i_data_byte <= b;
        i_num_bits  <= nb;
        do @(posedge i_clk); while (o_stall);
        if (m <= MODE_FIX64)
            bytes_sent++;
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(1, 6);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic test_single_byte_reads();
        stall_style <= STALL_NONE;
        gaps_on = 1'b0;
        send_byte(MODE_U8, 8'h00, 7'd0);
        send_byte(MODE_U8, 8'hFF, 7'h7F);
        send_byte(MODE_BOOL, 8'h00, 7'd0);
        send_byte(MODE_BOOL, 8'h01, 7'd0);
        send_byte(MODE_BOOL, 8'h02, 7'd0);
        send_byte(MODE_U7, 8'h7F, 7'd0);
        send_byte(MODE_U7, 8'h80, 7'd0);
        send_byte(MODE_U7, 8'hFF, 7'd0);
    endtask

    task automatic test_big_endian_reads();
        stall_style <= STALL_LIGHT;
        for (int i = 0; i < 4; i++)
            send_byte(MODE_U32BE, 8'hFF - 8'(i), 7'd0);
        for (int i = 0; i < 8; i++)
            send_byte(MODE_U64BE, 8'h01 + 8'(8'h22 * i), 7'd0);
    endtask

    task automatic test_fixed_reads();
        stall_style <= STALL_PERIODIC;
        gaps_on = 1'b1;
        send_byte(MODE_FIX32, 8'hA5, 7'd0);
        for (int i = 0; i < 4; i++)
            send_byte(MODE_FIX32, 8'h80 | 8'(i), 7'd127);
        send_byte(MODE_FIX64, 8'h5A, 7'd8);
        for (int i = 0; i < 8; i++)
            send_byte(MODE_FIX64, 8'hFF, 7'd65);
    endtask

    task automatic test_leb_reads();
        stall_style <= STALL_HEAVY;
        send_byte(MODE_U32LEB, 8'h7F, 7'd0);
        send_byte(MODE_S32LEB, 8'h40, 7'd0);
        for (int i = 0; i < 4; i++)
            send_byte(MODE_S32LEB, 8'hFF, 7'd0);
        send_byte(MODE_S32LEB, 8'h0F, 7'd0);
        // Five continuation bytes in a 32-bit read: overlong.
        for (int i = 0; i < LEB32_BYTES; i++)
            send_byte(MODE_U32LEB, 8'h80, 7'd0);
        send_byte(MODE_S64LEB, 8'h7F, 7'd0);
        // Ten bytes whose top bits fall off the end of the 64-bit word.
        for (int i = 0; i < LEB64_BYTES - 1; i++)
            send_byte(MODE_U64LEB, 8'hFF, 7'd0);
        send_byte(MODE_U64LEB, 8'h7F, 7'd0);
        for (int i = 0; i < LEB64_BYTES; i++)
            send_byte(MODE_S64LEB, 8'h81, 7'd0);
    endtask

    task automatic test_unused_and_mixed_modes();
        stall_style <= STALL_LIGHT;
        for (int m = MODE_FIX64 + 1; m < 16; m++)
            send_byte(4'(m), 8'hFF, 7'h7F);
        // An unused mode in the middle of a value must leave it untouched.
        send_byte(MODE_U32LEB, 8'h81, 7'd0);
        send_byte(4'hF, 8'h00, 7'd0);
        send_byte(MODE_U8, 8'h42, 7'd0);
        send_byte(MODE_U32BE, 8'hAA, 7'd0);
        send_byte(MODE_U32BE, 8'hBB, 7'd0);
        send_byte(MODE_U32LEB, 8'h05, 7'd0);
        send_byte(MODE_U32LEB, 8'h80, 7'd0);
        for (int i = 0; i < 3; i++)
            send_byte(MODE_U32BE, 8'h11 * 8'(i + 1), 7'd0);
    endtask

    task automatic test_long_hold_off();
        stall_style <= STALL_NONE;
        gaps_on = 1'b0;
        hold_req <= ~hold_req;
        for (int i = 0; i < 40; i++)
            send_byte(MODE_U8, 8'($urandom), 7'($urandom));
    endtask

    task automatic test_random_stream();
        int          start;
        int          pick;
        int          n;
        int          maxb;
        bit          overlong;
        logic [3:0]  m;
        logic [6:0]  nb;
        logic [7:0]  b;
        start = bytes_sent;
        for (int iter = 0; bytes_sent - start < RANDOM_BYTES; iter++) begin
            if (iter % 25 == 0) begin
                stall_style <= t_stall_style'($urandom_range(STALL_NONE, STALL_PERIODIC));
                gaps_on = ($urandom_range(0, 4) != 0);
            end
            m    = 4'($urandom_range(MODE_U8, MODE_FIX64));
            nb   = 7'($urandom_range(0, 127));
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_byte(4'($urandom_range(MODE_FIX64 + 1, 15)), biased_byte(), nb);
            end else if (pick < 20) begin
                // Broken value: a few bytes under one mode, closed by a raw byte read.
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    b    = biased_byte();
                    b[7] = 1'b1;
                    send_byte(m, b, nb);
                end
                send_byte(MODE_U8, biased_byte(), nb);
            end else begin
                case (m)
                    MODE_S32LEB, MODE_U32LEB, MODE_S64LEB, MODE_U64LEB: begin
                        maxb     = (m == MODE_S32LEB || m == MODE_U32LEB) ? LEB32_BYTES
                                                                         : LEB64_BYTES;
                        pick     = $urandom_range(0, 9);
                        overlong = (pick == 0);
                        n        = (pick < 3) ? maxb : $urandom_range(1, 3);
                        for (int i = 0; i < n; i++) begin
                            b    = biased_byte();
                            b[7] = overlong || (i < n - 1);
                            send_byte(m, b, nb);
                        end
                    end
                    MODE_BOOL: begin
                        b = ($urandom_range(0, 3) == 0) ? biased_byte()
                                                         : 8'($urandom_range(0, 1));
                        send_byte(m, b, nb);
                    end
                    MODE_U7: begin
                        b = biased_byte();
                        if ($urandom_range(0, 3) != 0)
                            b[7] = 1'b0;
                        send_byte(m, b, nb);
                    end
                    default: begin
                        n = (m == MODE_U32BE) ? 4 :
                            (m == MODE_U64BE) ? 8 :
                            (m == MODE_FIX32) ? fixed_bytes(nb, 4) :
                            (m == MODE_FIX64) ? fixed_bytes(nb, 8) : 1;
                        for (int i = 0; i < n; i++)
                            send_byte(m, biased_byte(), nb);
                    end
                endcase
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_single_byte_reads();
        test_big_endian_reads();
        test_fixed_reads();
        test_leb_reads();
        test_unused_and_mixed_modes();
        test_long_hold_off();
        test_random_stream();
        i_valid <= 1'b0;
        while (expected_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d values decoded from %0d stream bytes in every read mode,",
                 values_checked, bytes_sent);
        $display("with unused and switched modes; flagged: boolean %0d, byte %0d, overlong %0d.",
                 err_seen[ERR_BOOL], err_seen[ERR_BYTE], err_seen[ERR_LONG]);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
